// ----- rtl/rfss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rfss_pkg;

  localparam int PatternMax = 16;
  localparam int IndexBits  = 8;
  localparam int LenBits    = 5;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 64;

  localparam logic [7:0] CaseGap = 8'h20;
  localparam logic [7:0] UpperA  = 8'h41;
  localparam logic [7:0] UpperZ  = 8'h5A;

  localparam logic [7:0] IndexMask =
    (IndexBits >= 8) ? 8'hFF : 8'((1 << IndexBits) - 1);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_CASE_SENSITIVE = 3'd3,
    CFG_SEARCH_FIELDS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_NUMBER   = 2'd1,
    KIND_PASSWORD = 2'd2,
    KIND_NONE     = 2'd3
  } field_kind_e;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic [1:0] field_kind;
    logic       last_in_field;
    logic       last_in_record;
    logic [7:0] record_index;
  } in_req_t;

  typedef struct packed {
    logic [7:0] result_index;
    logic       found;
  } out_res_t;

  // pattern and compare mode handed to the match unit
  typedef struct packed {
    logic [2*CfgBits-1:0] pattern;
    logic [LenBits-1:0]   length;
    logic                 case_sensitive;
  } match_cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) r = c + CaseGap;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rfss_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rfss_match (
  input  wire  rfss_pkg::match_cfg_t          cfg_i,
  input  wire  logic [7:0]                    character_i,
  input  wire  logic [rfss_pkg::PatternMax-1:0] prefix_i,
  output logic [rfss_pkg::PatternMax-1:0]     prefix_o,
  output logic                                match_o
);
  import rfss_pkg::*;

  logic [7:0]            ch;
  logic [PatternMax-1:0] hit;
  logic [PatternMax-1:0] len_mask;

  assign ch = cfg_i.case_sensitive ? character_i : fold_case(character_i);

  // per-position compare, independent lanes
  always_comb begin
    logic [7:0] p;
    hit      = '0;
    len_mask = '0;
    p        = '0;
    for (int i = 0; i < PatternMax; i++) begin
      p = cfg_i.pattern[8*i +: 8];
      if (!cfg_i.case_sensitive) p = fold_case(p);
      hit[i]      = (p == ch);
      len_mask[i] = (LenBits'(i) < cfg_i.length);
    end
  end

  assign prefix_o = {prefix_i[PatternMax-2:0], 1'b1} & hit & len_mask;

  // top bit of the used pattern reached
  always_comb begin
    match_o = 1'b0;
    for (int i = 0; i < PatternMax; i++) begin
      if (cfg_i.length == LenBits'(i + 1)) match_o = prefix_o[i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/record_field_substring_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// record field substring search
// characters of directory records arrive one per request on the in channel
// (valid/ready), each tagged with its field kind and field/record end marks.
// a configured pattern of up to 16 characters is searched with a shift-and
// prefix vector inside every selected field, exact or ignoring ascii case.
// on the final item of a record one result request goes out on the out
// channel with the record index and the found flag.
// an item is captured in the input register when it is accepted; the item
// that closes a record loads its result into the output register as the
// input stage advances, and out_valid_o rises with that load.
// throughput: one item per cycle unless a held result blocks the input
// stage, set by the single compare/shift step between the two registers.
// a stalled receiver holds the result; the input stage keeps moving while
// the output register is free or being drained, and backs up otherwise.
// reset clears the pipeline, the prefix vector, the found flag and loads
// the register reset values (search all fields, empty pattern).
// configuration writes take effect at once and are meant for idle periods.
module record_field_substring_search_top (
  input  wire  logic                                clk_i,
  input  wire  logic                                rst_ni,
  input  wire  logic                                in_valid_i,
  output logic                                      in_ready_o,
  input  wire  rfss_pkg::in_req_t                   in_req_i,
  output logic                                      out_valid_o,
  input  wire  logic                                out_ready_i,
  output rfss_pkg::out_res_t                        out_res_o,
  input  wire  logic                                cfg_we_i,
  input  wire  logic [rfss_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire  logic [rfss_pkg::CfgBits-1:0]        cfg_wdata_i
);
  import rfss_pkg::*;

  // configuration registers
  logic [CfgBits-1:0] pat_low_q, pat_high_q;
  logic [LenBits-1:0] pat_len_q;
  logic               case_sens_q;
  logic [2:0]         fields_q;

  // input stage
  logic    s1_valid_q;
  in_req_t s1_q;
  logic    advance;

  // search state
  logic [PatternMax-1:0] prefix_q, prefix_d;
  logic                  found_q, found_d;
  logic [PatternMax-1:0] prefix_new;
  logic                  match;

  // result register
  logic     out_valid_q, out_valid_d;
  out_res_t out_q;

  match_cfg_t mcfg;
  logic [LenBits-1:0] used_len;
  logic               selected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      pat_len_q   <= '0;
      case_sens_q <= 1'b0;
      fields_q    <= 3'b111;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_LOW:    pat_low_q   <= cfg_wdata_i;
        CFG_PATTERN_HIGH:   pat_high_q  <= cfg_wdata_i;
        CFG_PATTERN_LENGTH: pat_len_q   <= cfg_wdata_i[LenBits-1:0];
        CFG_CASE_SENSITIVE: case_sens_q <= cfg_wdata_i[0];
        CFG_SEARCH_FIELDS:  fields_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // lengths above the pattern store saturate
  assign used_len = (pat_len_q > LenBits'(PatternMax)) ? LenBits'(PatternMax) : pat_len_q;

  assign mcfg.pattern        = {pat_high_q, pat_low_q};
  assign mcfg.length         = used_len;
  assign mcfg.case_sensitive = case_sens_q;

  // the input stage moves on whenever the result slot is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_req_i;
    end
  end

  rfss_match u_match (
    .cfg_i       (mcfg),
    .character_i (s1_q.character),
    .prefix_i    (prefix_q),
    .prefix_o    (prefix_new),
    .match_o     (match)
  );

  // kind three is never searched
  always_comb begin
    case (field_kind_e'(s1_q.field_kind))
      KIND_NAME:     selected = fields_q[0];
      KIND_NUMBER:   selected = fields_q[1];
      KIND_PASSWORD: selected = fields_q[2];
      default:       selected = 1'b0;
    endcase
  end

  always_comb begin
    prefix_d    = prefix_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance) begin
      if (selected) begin
        if (used_len == '0) begin
          // empty pattern hits any item of a selected field
          found_d = 1'b1;
        end else if (s1_q.has_char) begin
          prefix_d = prefix_new;
          if (match) found_d = 1'b1;
        end
      end
      if (s1_q.last_in_field) prefix_d = '0;
      if (s1_q.last_in_record) begin
        out_valid_d = 1'b1;
        found_d     = 1'b0;
        prefix_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prefix_q    <= prefix_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, found includes a hit by the closing item itself
  always_ff @(posedge clk_i) begin
    if (advance && s1_q.last_in_record) begin
      out_q.result_index <= s1_q.record_index & IndexMask;
      out_q.found <= found_q || (selected && ((used_len == '0) ||
                     (s1_q.has_char && match)));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef NO_ASSERTIONS
  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.last_in_record |=> out_valid_q)
    else $error("record end did not load a result");

  a_close_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.last_in_record |=> (found_q == 1'b0) && (prefix_q == '0))
    else $error("search state not cleared at record end");

  a_field_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.last_in_field |=> prefix_q == '0)
    else $error("prefix vector not cleared at field end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("input stage advanced into a held result");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty input stage not ready");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_record_field_substring_search_top.sv -----
`timescale 1ns / 1ps

module tb_record_field_substring_search_top;
  import rfss_pkg::*;

  localparam int WatchdogLimit = 2000;
  // extra wait after the last report so that the pipe can empty
  localparam int DrainCycles   = 4;
  localparam int RandomItems   = 1800;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // dut ports
  logic                  in_valid   = 1'b0;
  logic                  in_ready_o;
  in_req_t               in_req     = '0;
  logic                  out_valid_o;
  logic                  out_ready  = 1'b0;
  out_res_t              out_res_o;
  logic                  cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index  = '0;
  logic [CfgBits-1:0]    cfg_wdata  = '0;

  record_field_substring_search_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow copy of the search registers, reset values
  logic [15:0][7:0] pat_q     = '0;
  logic [4:0]       pat_len_q = '0;
  logic             exact_q   = 1'b0;
  logic [2:0]       fields_q  = 3'd7;

  // shadow of the match state
  logic [15:0] prefix_q = '0;
  logic        hit_q    = 1'b0;

  in_req_t     char_queue[$];    // requests waiting to be driven
  out_res_t    report_queue[$];  // record reports still to come out
  logic [7:0]  text_buf[$];      // scratch text of one field
  int unsigned items_queued = 0;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // one shift-and step; returns 1 when the request closes a record
  function automatic bit scan_char(input in_req_t req, output out_res_t rpt);
    logic [4:0]  n;
    logic [7:0]  c;
    logic [7:0]  p;
    logic [15:0] hits;
    logic [15:0] mask;
    bit          sel;
    rpt  = '0;
    n    = (pat_len_q > 5'd16) ? 5'd16 : pat_len_q;
    sel  = (req.field_kind != KIND_NONE) && fields_q[req.field_kind];
    mask = 16'((17'd1 << n) - 17'd1);
    if (sel) begin
      if (n == 5'd0) begin
        hit_q = 1'b1;
      end else if (req.has_char) begin
        c    = exact_q ? req.character : to_lower(req.character);
        hits = '0;
        for (int i = 0; i < 16; i++) begin
          p = exact_q ? pat_q[i] : to_lower(pat_q[i]);
          if (i < n && p == c) hits[i] = 1'b1;
        end
        prefix_q = ((prefix_q << 1) | 16'd1) & hits & mask;
        if (prefix_q[n - 5'd1]) hit_q = 1'b1;
      end
    end
    if (req.last_in_field) prefix_q = '0;
    if (req.last_in_record) begin
      rpt.result_index = req.record_index;
      rpt.found        = hit_q;
      hit_q            = 1'b0;
      prefix_q         = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // mostly a small alphabet so that partial matches are common
  function automatic logic [7:0] rand_char();
    string alpha = "aAbBc";
    return ($urandom_range(99) < 65) ? alpha[$urandom_range(4)] : 8'($urandom_range(255));
  endfunction

  task automatic push_item(input logic [7:0] ch, input bit has, input field_kind_e kind,
                           input bit lf, input bit lr, input logic [7:0] idx);
    in_req_t r;
    r.character      = ch;
    r.has_char       = has;
    r.field_kind     = kind;
    r.last_in_field  = lf;
    r.last_in_record = lr;
    r.record_index   = idx;
    char_queue.push_back(r);
    items_queued++;
  endtask

  task automatic text_from(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // sends text_buf as one field; empty text becomes the empty-field marker
  task automatic push_field(input field_kind_e kind, input bit close_field,
                            input bit close_rec, input logic [7:0] idx, input bit noisy);
    logic [7:0] tag;
    bit         tail;
    if (text_buf.size() == 0) begin
      push_item(8'($urandom_range(255)), 1'b0, kind, close_field, close_rec, idx);
    end else begin
      foreach (text_buf[i]) begin
        tail = (i == text_buf.size() - 1);
        // stray no-character requests in the middle of a field
        if (noisy && $urandom_range(99) < 6)
          push_item(8'($urandom_range(255)), 1'b0, kind, 1'b0, 1'b0, 8'($urandom_range(255)));
        // only the closing request's index is reported
        tag = (noisy && !tail && $urandom_range(99) < 5) ? 8'($urandom_range(255)) : idx;
        push_item(text_buf[i], 1'b1, kind, tail && close_field, tail && close_rec, tag);
      end
    end
  endtask

  // one record of one to three fields, often holding the pattern
  task automatic gen_record();
    int unsigned n_fields;
    int unsigned pick;
    int unsigned k;
    logic [4:0]  n;
    logic [7:0]  idx;
    logic [7:0]  ch;
    field_kind_e kind;
    bit          close_field;
    idx      = 8'($urandom_range(255));
    n        = (pat_len_q > 5'd16) ? 5'd16 : pat_len_q;
    n_fields = $urandom_range(1, 3);
    for (int f = 0; f < n_fields; f++) begin
      kind = ($urandom_range(99) < 10) ? KIND_NONE : field_kind_e'(2'($urandom_range(2)));
      text_buf.delete();
      pick = $urandom_range(99);
      if (pick >= 10) begin
        repeat ($urandom_range(4)) text_buf.push_back(rand_char());
        if (pick < 60) begin
          k = n;
          // pattern cut short so the field ends on a partial match
          if (k > 0 && $urandom_range(99) < 15) k = $urandom_range(k - 1);
          for (int i = 0; i < k; i++) begin
            ch = pat_q[i];
            // flip letter case; only exact compare should miss
            if (to_lower(ch | 8'h20) == (ch | 8'h20) && (ch | 8'h20) >= 8'h61 &&
                (ch | 8'h20) <= 8'h7A && $urandom_range(99) < 30)
              ch = ch ^ 8'h20;
            text_buf.push_back(ch);
          end
        end
        repeat ($urandom_range(3)) text_buf.push_back(rand_char());
      end
      // now and then a field runs on without its end mark
      close_field = ($urandom_range(99) >= 4);
      push_field(kind, close_field, f == n_fields - 1, idx, 1'b1);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgBits-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_config();
    write_reg(CFG_PATTERN_LOW, pat_q[7:0]);
    write_reg(CFG_PATTERN_HIGH, pat_q[15:8]);
    write_reg(CFG_PATTERN_LENGTH, CfgBits'(pat_len_q));
    write_reg(CFG_CASE_SENSITIVE, CfgBits'(exact_q));
    write_reg(CFG_SEARCH_FIELDS, CfgBits'(fields_q));
  endtask

  // wait until everything sent has been reported, then let the pipe empty
  task automatic settle();
    while (char_queue.size() != 0 || in_valid || report_queue.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // driver: predict at each accept, then offer the next request
  always @(posedge clk_i) begin : drive_chars
    bit       fire;
    out_res_t rpt;
    if (rst_ni) begin
      fire = in_valid && in_ready_o;
      if (fire && scan_char(in_req, rpt)) report_queue.push_back(rpt);
      if ((!in_valid || fire) && char_queue.size() != 0 &&
          (no_idle || $urandom_range(99) >= 30)) begin
        in_req   <= char_queue.pop_front();
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each report with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    out_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (report_queue.size() == 0) begin
          $error("unexpected report: result_index %0d found %0d",
                 out_res_o.result_index, out_res_o.found);
          error_count++;
        end else begin
          want = report_queue.pop_front();
          if (out_res_o.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index,
                   out_res_o.result_index);
            error_count++;
          end
          if (out_res_o.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_res_o.found);
            error_count++;
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_record_field_substring_search_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: empty pattern, all fields searched
    text_from("z");
    push_field(KIND_NAME, 1'b1, 1'b1, 8'd0, 1'b0);
    settle();

    // "Ab" ignoring case
    pat_q     = '0;
    pat_q[0]  = 8'h41;
    pat_q[1]  = 8'h62;
    pat_len_q = 5'd2;
    exact_q   = 1'b0;
    fields_q  = 3'd7;
    load_config();
    text_from("xaB");    // match in other case
    push_field(KIND_NAME, 1'b1, 1'b1, 8'd1, 1'b0);
    text_from("a");      // partial match cut off at field end
    push_field(KIND_NAME, 1'b1, 1'b0, 8'd2, 1'b0);
    text_from("b");
    push_field(KIND_NUMBER, 1'b1, 1'b1, 8'd2, 1'b0);
    text_buf.delete();   // empty field, non-empty pattern
    push_field(KIND_NAME, 1'b1, 1'b1, 8'd3, 1'b0);
    text_from("ab");     // field kind three is never searched
    push_field(KIND_NONE, 1'b1, 1'b1, 8'd4, 1'b0);
    // byte extremes, and a no-character request inside the match
    push_item(8'h00, 1'b1, KIND_PASSWORD, 1'b0, 1'b0, 8'd255);
    push_item(8'hFF, 1'b1, KIND_PASSWORD, 1'b0, 1'b0, 8'd255);
    push_item(8'h61, 1'b1, KIND_PASSWORD, 1'b0, 1'b0, 8'd255);
    push_item(8'h7A, 1'b0, KIND_PASSWORD, 1'b0, 1'b0, 8'd255);
    push_item(8'h62, 1'b1, KIND_PASSWORD, 1'b1, 1'b1, 8'd255);
    settle();

    // empty pattern, number fields only
    pat_len_q = 5'd0;
    exact_q   = 1'b1;
    fields_q  = 3'b010;
    load_config();
    text_buf.delete();   // empty marker of a selected field still matches
    push_field(KIND_NUMBER, 1'b1, 1'b1, 8'd6, 1'b0);
    text_from("q");
    push_field(KIND_NAME, 1'b1, 1'b0, 8'd7, 1'b0);
    text_buf.delete();
    push_field(KIND_NONE, 1'b1, 1'b1, 8'd7, 1'b0);
    settle();

    // "aB" exact
    pat_q[0]  = 8'h61;
    pat_q[1]  = 8'h42;
    pat_len_q = 5'd2;
    fields_q  = 3'd7;
    load_config();
    text_from("ab");
    push_field(KIND_NAME, 1'b1, 1'b1, 8'd8, 1'b0);
    text_from("aB");
    push_field(KIND_NUMBER, 1'b1, 1'b1, 8'd9, 1'b0);

    // random phases, each with its own search setting
    target = items_queued + RandomItems;
    for (int p = 0; items_queued < target; p++) begin
      settle();
      if (p == 0) begin
        // all-ones pattern at full length
        foreach (pat_q[i]) pat_q[i] = 8'hFF;
        pat_len_q = 5'd16;
        exact_q   = 1'b1;
        fields_q  = 3'd7;
      end else if (p == 1) begin
        // length beyond the maximum, nothing searched
        pat_q     = '0;
        pat_len_q = 5'd31;
        exact_q   = 1'b0;
        fields_q  = 3'd0;
      end else begin
        foreach (pat_q[i]) pat_q[i] = rand_char();
        pick = $urandom_range(99);
        if (pick < 8)       pat_len_q = 5'd0;
        else if (pick < 70) pat_len_q = 5'($urandom_range(1, 4));
        else if (pick < 80) pat_len_q = 5'($urandom_range(5, 15));
        else if (pick < 90) pat_len_q = 5'd16;
        else                pat_len_q = 5'($urandom_range(17, 31));
        exact_q  = 1'($urandom_range(1));
        fields_q = ($urandom_range(99) < 50) ? 3'd7 : 3'($urandom_range(7));
      end
      load_config();
      // one long phase where neither side idles
      no_idle = (p == 3);
      pick = items_queued + ((p == 3) ? 300 : $urandom_range(60, 160));
      while (items_queued < pick) gen_record();
    end

    settle();
    no_idle = 1'b0;
    repeat (6) @(posedge clk_i);
    if (error_count == 0 && report_queue.size() == 0) begin
      $display("tb_record_field_substring_search_top: PASS");
    end else begin
      $display("tb_record_field_substring_search_top: FAIL");
    end
    $finish;
  end

endmodule
